// ----- src/vpp_pkg.sv -----
`default_nettype none

package vpp_pkg;

	// Configuration register file: eight 64-bit words, two Q-format entries each.
	localparam int CFG_NUM = 8;
	localparam int CFG_W   = 64;
	localparam int CFG_IW  = $clog2(CFG_NUM);

	// Register indexes.
	localparam logic [CFG_IW-1:0] REG_ROW0_C01 = 3'd0;
	localparam logic [CFG_IW-1:0] REG_ROW0_C23 = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ROW1_C01 = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ROW1_C23 = 3'd3;
	localparam logic [CFG_IW-1:0] REG_ROW2_C01 = 3'd4;
	localparam logic [CFG_IW-1:0] REG_ROW2_C23 = 3'd5;
	localparam logic [CFG_IW-1:0] REG_ROW3_C01 = 3'd6;
	localparam logic [CFG_IW-1:0] REG_ROW3_C23 = 3'd7;

	typedef logic [CFG_W-1:0] cfg_word_t;

	// Reset image of the register file, indexed by register index.
	localparam cfg_word_t CFG_RESET [CFG_NUM] = '{
		64'h0000_0001_0000_0000,
		64'h0,
		64'h0000_0000_0001_0000,
		64'h0,
		64'h0,
		64'h0000_0001_0000_0000,
		64'h0,
		64'h0000_0000_0001_0000
	};

	// Quotient bits resolved by each divider, one per pipeline stage.
	localparam int DIV_QB  = 32;
	// Divider depth: one input stage plus one stage per quotient bit.
	localparam int DIV_LAT = DIV_QB + 1;

	// Sideband that rides alongside the dividers.
	typedef struct packed {
		logic w_zero;
		logic neg_z;
		logic neg_y;
		logic neg_x;
	} side_t;

endpackage

`default_nettype wire

// ----- src/vpp_div.sv -----
`default_nettype none

module vpp_div #(
	parameter int NW = 66,
	parameter int DW = 50
) (
	input  wire logic                      clk,
	input  wire logic [NW-1:0]             num,
	input  wire logic [DW-1:0]             den,
	output logic      [vpp_pkg::DIV_QB-1:0] quo,
	output logic                           ovf
);
	import vpp_pkg::*;

	localparam int WW = ((NW > DW) ? NW : DW) + DIV_QB;

	logic [NW-1:0]     rem_s [DIV_QB+1];
	logic [DW-1:0]     den_s [DIV_QB+1];
	logic [DIV_QB-1:0] quo_s [DIV_QB+1];
	logic              ovf_s [DIV_QB+1];

	// Input stage: flag quotients that do not fit in DIV_QB bits (also zero divisor).
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= (WW'(num) >= (WW'(den) << DIV_QB));
	end

	// One restoring step per stage, most significant quotient bit first.
	for (genvar k = 1; k <= DIV_QB; k++) begin : g_step
		localparam int SH = DIV_QB - k;
		logic [WW-1:0] trial;
		logic [WW-1:0] diff;
		logic          take;

		always_comb begin
			trial = WW'(den_s[k-1]) << SH;
			take  = (WW'(rem_s[k-1]) >= trial);
			diff  = WW'(rem_s[k-1]) - trial;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? NW'(diff) : rem_s[k-1];
			quo_s[k] <= quo_s[k-1] | (take ? (DIV_QB'(1) << SH) : '0);
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo = quo_s[DIV_QB];
	assign ovf = ovf_s[DIV_QB];

endmodule

`default_nettype wire

// ----- src/vertex_projection_to_pixel.sv -----
`default_nettype none

// Vertex projection to pixel. A vertex (vert_x, vert_y, vert_z, w = 1) is
// taken on every clock edge where start is high; busy never rises, so a new
// vertex may follow in each cycle. Each vertex gives exactly one result beat,
// flagged by done for a single cycle. done cannot be held off,
// so the receiver must take every beat as it comes.
// The latency is set by the three 32-stage restoring dividers (x/w, y/w,
// z/w, one quotient bit per stage, behind one input stage that flags an
// oversized quotient), plus four stages in front (input, twelve 32x32
// multiplies, row sums, magnitudes) and three behind (saturation, frame test
// with row*width, address times three), forty register stages in all.
// The matrix registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no vertex is in flight. A zero w returns all-zero
// results with w_zero set; an out-of-frame pixel returns byte_address zero.

module vertex_projection_to_pixel #(
	parameter int LINE_PIXELS = 720,
	parameter int FRAME_LINES = 480,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [vpp_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [vpp_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [31:0]           vert_x,
	input  wire logic signed [31:0]           vert_y,
	input  wire logic signed [31:0]           vert_z,
	output logic                              done,
	output logic signed [15:0]                pixel_x,
	output logic signed [15:0]                pixel_y,
	output logic signed [31:0]                depth_value,
	output logic [19:0]                       byte_address,
	output logic                              in_frame,
	output logic                              w_zero
);
	import vpp_pkg::*;

	// Row sum width: a product shifted down by FRAC_BITS, plus headroom for four terms.
	localparam int SW = 66 - FRAC_BITS;
	// Divider numerator width: depth needs the magnitude scaled by FRAC_BITS.
	localparam int NW = SW + FRAC_BITS;

	// ---------------------------------------------------------------
	// Matrix registers
	// ---------------------------------------------------------------
	cfg_word_t cfg_q [CFG_NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) begin
				cfg_q[i] <= CFG_RESET[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Unpack entries: even column in the high half, odd column in the low half.
	logic signed [31:0] mat [4][4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			mat[r][0] = cfg_q[2*r][63:32];
			mat[r][1] = cfg_q[2*r][31:0];
			mat[r][2] = cfg_q[2*r+1][63:32];
			mat[r][3] = cfg_q[2*r+1][31:0];
		end
	end

	// The block takes a beat every cycle.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// ---------------------------------------------------------------
	// Stage 1: capture the vertex
	// ---------------------------------------------------------------
	logic               v_s1;
	logic signed [31:0] vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		vx_s1 <= vert_x;
		vy_s1 <= vert_y;
		vz_s1 <= vert_z;
	end

	// ---------------------------------------------------------------
	// Stage 2: twelve exact products, one per matrix entry in columns 0..2
	// ---------------------------------------------------------------
	logic               v_s2;
	logic signed [63:0] prod_s2 [4][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			prod_s2[r][0] <= mat[r][0] * vx_s1;
			prod_s2[r][1] <= mat[r][1] * vy_s1;
			prod_s2[r][2] <= mat[r][2] * vz_s1;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: floor-shift each product and add the translation column
	// ---------------------------------------------------------------
	logic               v_s3;
	logic signed [SW-1:0] hsum_s3 [4];
	logic signed [SW-1:0] hsum    [4];
	logic signed [63:0]   shifted [4][3];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				shifted[r][c] = prod_s2[r][c] >>> FRAC_BITS;
			end
			hsum[r] = $signed(shifted[r][0][SW-1:0]) + $signed(shifted[r][1][SW-1:0])
				+ $signed(shifted[r][2][SW-1:0]) + SW'(mat[r][3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			hsum_s3[r] <= hsum[r];
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: split into sign and magnitude for the unsigned dividers
	// ---------------------------------------------------------------
	logic          v_s4;
	logic [SW-1:0] nmag_s4 [3];
	logic [SW-1:0] dmag_s4;
	side_t         side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			nmag_s4[r] <= hsum_s3[r][SW-1] ? SW'(-hsum_s3[r]) : hsum_s3[r];
		end
		dmag_s4       <= hsum_s3[3][SW-1] ? SW'(-hsum_s3[3]) : hsum_s3[3];
		side_s4.w_zero <= (hsum_s3[3] == '0);
		side_s4.neg_x  <= hsum_s3[0][SW-1] ^ hsum_s3[3][SW-1];
		side_s4.neg_y  <= hsum_s3[1][SW-1] ^ hsum_s3[3][SW-1];
		side_s4.neg_z  <= hsum_s3[2][SW-1] ^ hsum_s3[3][SW-1];
	end

	// ---------------------------------------------------------------
	// Dividers: integer quotient for x and y, scaled quotient for depth
	// ---------------------------------------------------------------
	logic [DIV_QB-1:0] qx, qy, qz;
	logic              ox, oy, oz;

	vpp_div #(.NW(NW), .DW(SW)) u_div_x (
		.clk (clk),
		.num (NW'(nmag_s4[0])),
		.den (dmag_s4),
		.quo (qx),
		.ovf (ox)
	);

	vpp_div #(.NW(NW), .DW(SW)) u_div_y (
		.clk (clk),
		.num (NW'(nmag_s4[1])),
		.den (dmag_s4),
		.quo (qy),
		.ovf (oy)
	);

	vpp_div #(.NW(NW), .DW(SW)) u_div_z (
		.clk (clk),
		.num ({nmag_s4[2], {FRAC_BITS{1'b0}}}),
		.den (dmag_s4),
		.quo (qz),
		.ovf (oz)
	);

	// Valid and sign flags travel beside the dividers.
	logic  vld_q  [DIV_LAT];
	side_t side_q [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= v_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s4;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: apply signs and saturate
	// ---------------------------------------------------------------
	function automatic logic [15:0] pix_sat(input logic [DIV_QB-1:0] q, input logic ovf,
		input logic neg);
		logic [15:0] res;
		if (neg) begin
			res = (ovf || q > DIV_QB'(32768)) ? 16'h8000 : 16'(16'd0 - q[15:0]);
		end else begin
			res = (ovf || q > DIV_QB'(32767)) ? 16'h7FFF : q[15:0];
		end
		return res;
	endfunction

	function automatic logic [31:0] dep_sat(input logic [DIV_QB-1:0] q, input logic ovf,
		input logic neg);
		logic [31:0] res;
		if (neg) begin
			res = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - q[31:0]);
		end else begin
			res = (ovf || q[31]) ? 32'h7FFF_FFFF : q[31:0];
		end
		return res;
	endfunction

	logic               v_s5;
	logic signed [15:0] px_s5, py_s5;
	logic signed [31:0] dz_s5;
	logic               wz_s5;
	side_t              side_div;

	assign side_div = side_q[DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= vld_q[DIV_LAT-1];
		end
	end

	// Zero w forces every coordinate to zero.
	always_ff @(posedge clk) begin
		wz_s5 <= side_div.w_zero;
		px_s5 <= side_div.w_zero ? '0 : pix_sat(qx, ox, side_div.neg_x);
		py_s5 <= side_div.w_zero ? '0 : pix_sat(qy, oy, side_div.neg_y);
		dz_s5 <= side_div.w_zero ? '0 : dep_sat(qz, oz, side_div.neg_z);
	end

	// ---------------------------------------------------------------
	// Stage 6: frame test and linear pixel index
	// ---------------------------------------------------------------
	logic               v_s6;
	logic signed [15:0] px_s6, py_s6;
	logic signed [31:0] dz_s6;
	logic               wz_s6;
	logic               inside_s6;
	logic [31:0]        lin_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		px_s6     <= px_s5;
		py_s6     <= py_s5;
		dz_s6     <= dz_s5;
		wz_s6     <= wz_s5;
		inside_s6 <= !wz_s5 && !px_s5[15] && !py_s5[15]
			&& (32'(px_s5) < 32'(LINE_PIXELS)) && (32'(py_s5) < 32'(FRAME_LINES));
		lin_s6    <= 32'(LINE_PIXELS) * 32'(py_s5[14:0]) + 32'(px_s5[14:0]);
	end

	// ---------------------------------------------------------------
	// Output register: byte offset is three bytes per pixel
	// ---------------------------------------------------------------
	logic               done_q;
	logic signed [15:0] pixel_x_q, pixel_y_q;
	logic signed [31:0] depth_q;
	logic [19:0]        addr_q;
	logic               in_frame_q, w_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		pixel_x_q  <= px_s6;
		pixel_y_q  <= py_s6;
		depth_q    <= dz_s6;
		w_zero_q   <= wz_s6;
		in_frame_q <= inside_s6;
		addr_q     <= inside_s6 ? 20'({lin_s6, 1'b0} + 33'(lin_s6)) : '0;
	end

	assign done         = done_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign depth_value  = depth_q;
	assign byte_address = addr_q;
	assign in_frame     = in_frame_q;
	assign w_zero       = w_zero_q;

endmodule

`default_nettype wire

// ----- src/vpp_chk.sv -----
`default_nettype none

module vpp_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               done,
	input wire logic signed [15:0] pixel_x,
	input wire logic signed [15:0] pixel_y,
	input wire logic signed [31:0] depth_value,
	input wire logic [19:0]        byte_address,
	input wire logic               in_frame,
	input wire logic               w_zero
);

	// A zero-w beat is never inside the frame.
	a_wz_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(w_zero && in_frame))
		else $error("w_zero and in_frame both set");

	// A zero-w beat carries all-zero coordinates.
	a_wz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && w_zero) |-> (pixel_x == 16'sd0 && pixel_y == 16'sd0
			&& depth_value == 32'sd0 && byte_address == 20'd0))
		else $error("nonzero result on zero w");

	// A pixel outside the frame carries a zero address.
	a_out_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_frame) |-> (byte_address == 20'd0))
		else $error("address set outside frame");

	// An in-frame pixel has nonnegative coordinates.
	a_in_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && in_frame) |-> (!pixel_x[15] && !pixel_y[15]))
		else $error("negative coordinate reported in frame");

endmodule

bind vertex_projection_to_pixel vpp_chk u_vpp_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.done         (done),
	.pixel_x      (pixel_x),
	.pixel_y      (pixel_y),
	.depth_value  (depth_value),
	.byte_address (byte_address),
	.in_frame     (in_frame),
	.w_zero       (w_zero)
);

`default_nettype wire
